[src/fitness_table_roulette_select_core_assert.svh]
// Assertion macros shared by the fitness table RTL.
`ifndef FITNESS_TABLE_ROULETTE_SELECT_CORE_ASSERT_SVH
`define FITNESS_TABLE_ROULETTE_SELECT_CORE_ASSERT_SVH

// same-cycle implication
`define FTRS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define FTRS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[src/ftrs_pkg.sv]
// ----------------------------------------------------------------------------
// ftrs_pkg
// Types and constants for the fitness table with roulette-wheel selection.
// ----------------------------------------------------------------------------
package ftrs_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int SCORE_BITS  = 16;

   localparam int TYPE_BITS   = 2;
   localparam int POS_BITS    = 6;
   localparam int IN_SCORE_BITS = 16;
   localparam int ID_BITS     = 6;
   localparam int RAND_BITS   = 31;
   localparam int CFG_BITS    = 7;
   localparam int CFG_RESET   = 64;

   localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS    = IDX_BITS + 1;
   localparam int SUM_BITS    = SCORE_BITS + IDX_BITS;
   localparam int USE_BITS    = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
   localparam int STEP_BITS   = $clog2(RAND_BITS);

   typedef enum logic [TYPE_BITS-1:0] {
      REQ_WRITE  = 2'd0,
      REQ_SORT   = 2'd1,
      REQ_SELECT = 2'd2,
      REQ_ARGMAX = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT_LOAD,
      ST_SORT_SCAN,
      ST_SORT_STORE,
      ST_SUM,
      ST_MOD,
      ST_SEL_SCAN,
      ST_ARG_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    id;
      logic [SCORE_BITS-1:0] score;
   } entry_type;

   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      entry_type           wr_data;
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_addr;
   } table_cmd_type;

endpackage

[src/ftrs_table.sv]
// ----------------------------------------------------------------------------
// ftrs_table
// Score/identifier memory, one write and one registered read per cycle.
// Entries never written read as score zero and identifier equal to position.
// ----------------------------------------------------------------------------
module ftrs_table (
   input  logic                   clock,
   input  logic                   reset,
   input  ftrs_pkg::table_cmd_type cmd,
   output ftrs_pkg::entry_type    rd_data
);
   import ftrs_pkg::*;

   entry_type             mem [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff;
   entry_type             rd_raw_ff;
   logic                  rd_valid_ff;
   logic [IDX_BITS-1:0]   rd_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[cmd.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_raw_ff   <= mem[cmd.rd_addr];
         rd_valid_ff <= valid_ff[cmd.rd_addr];
         rd_addr_ff  <= cmd.rd_addr;
      end
   end

   always_comb begin
      if (rd_valid_ff) begin
         rd_data = rd_raw_ff;
      end else begin
         rd_data.id    = ID_BITS'(rd_addr_ff);
         rd_data.score = '0;
      end
   end

endmodule

[src/ftrs_mod.sv]
// ----------------------------------------------------------------------------
// ftrs_mod
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`include "fitness_table_roulette_select_core_assert.svh"

module ftrs_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ftrs_pkg::RAND_BITS-1:0] dividend,
   input  logic [ftrs_pkg::SUM_BITS-1:0]  divisor,
   output logic                          done,
   output logic [ftrs_pkg::SUM_BITS-1:0]  remainder
);
   import ftrs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [RAND_BITS-1:0] dvd_ff, dvd_in;
   logic [SUM_BITS-1:0]  div_ff, div_in;
   logic [SUM_BITS-1:0]  rem_ff, rem_in;
   logic [SUM_BITS:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[RAND_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_BITS'(RAND_BITS - 1);
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below divisor, so trial - divisor fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = SUM_BITS'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[SUM_BITS-1:0];
         end
         dvd_in = {dvd_ff[RAND_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   `FTRS_ASSERT_IMP(a_rem_below_div, clock, reset, busy_ff, rem_ff < div_ff)
   `FTRS_ASSERT_NXT(a_start_busy, clock, reset, start, busy_ff)
   `FTRS_ASSERT_IMP(a_done_idle, clock, reset, done_ff, !busy_ff)

endmodule

[src/fitness_table_roulette_select_core.sv]
// ----------------------------------------------------------------------------
// fitness_table_roulette_select_core
// Fitness score table: write, descending exchange sort, roulette select and
// argmax over the entries in use.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  req_*     | in        | req_valid/ready    | type, position, score, id, random
//  rsp_*     | out       | rsp_valid/ready    | chosen position, chosen id, zero flag
//  csr_*     | in        | csr_wr_en          | entries in use (7 bits)
//
// One request at a time; the table has one read and one write port and
// scans one entry per cycle. A select runs a sum pass, a bit-serial
// remainder and a pick pass; a zero total ends it after the sum pass.
// A result waiting on rsp_ready holds the next request only at its own
// final step. Synchronous reset clears the table.
// ----------------------------------------------------------------------------
`include "fitness_table_roulette_select_core_assert.svh"

module fitness_table_roulette_select_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ftrs_pkg::TYPE_BITS-1:0]     req_type,
   input  logic [ftrs_pkg::POS_BITS-1:0]      req_position,
   input  logic [ftrs_pkg::IN_SCORE_BITS-1:0] req_score,
   input  logic [ftrs_pkg::ID_BITS-1:0]       req_entry_id,
   input  logic [ftrs_pkg::RAND_BITS-1:0]     req_random_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ftrs_pkg::POS_BITS-1:0]      rsp_chosen_position,
   output logic [ftrs_pkg::ID_BITS-1:0]       rsp_chosen_id,
   output logic                               rsp_zero_total,
   input  logic                               csr_wr_en,
   input  logic [ftrs_pkg::CFG_BITS-1:0]      csr_wr_data
);
   import ftrs_pkg::*;

   state_type            state_ff, state_in;
   req_kind_type         kind_ff, kind_in;
   logic [CFG_BITS-1:0]  cfg_ff;
   logic [RAND_BITS-1:0] rand_ff, rand_in;
   logic [IDX_BITS-1:0]  i_ff, i_in;
   logic [IDX_BITS-1:0]  j_ff, j_in;
   entry_type            cur_ff, cur_in;
   logic [SUM_BITS-1:0]  acc_ff, acc_in;
   logic [SUM_BITS-1:0]  total_ff, total_in;
   logic [SUM_BITS-1:0]  r_ff, r_in;
   logic [IDX_BITS-1:0]  best_pos_ff, best_pos_in;
   logic [POS_BITS-1:0]  res_pos_ff, res_pos_in;
   logic [ID_BITS-1:0]   res_id_ff, res_id_in;
   logic                 res_zero_ff, res_zero_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0]  rsp_pos_ff;
   logic [ID_BITS-1:0]   rsp_id_ff;
   logic                 rsp_zero_ff;

   logic [USE_BITS-1:0]  cfg_wide;
   logic [IDX_BITS-1:0]  last_idx;
   logic [SUM_BITS-1:0]  run_sum;
   logic                 req_fire;
   logic                 out_free;
   logic                 mod_start;
   logic                 mod_done;
   logic [SUM_BITS-1:0]  mod_rem;
   table_cmd_type        cmd;
   entry_type            rd;

   ftrs_table u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (rd)
   );

   ftrs_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rand_ff),
      .divisor   (run_sum),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // zero acts as one entry, anything past the table as the whole table
   always_comb begin
      cfg_wide = USE_BITS'(cfg_ff);
      if (cfg_wide == '0) begin
         last_idx = '0;
      end else if (cfg_wide > USE_BITS'(MAX_ENTRIES)) begin
         last_idx = IDX_BITS'(MAX_ENTRIES - 1);
      end else begin
         last_idx = IDX_BITS'(cfg_wide - USE_BITS'(1));
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign run_sum   = acc_ff + SUM_BITS'(rd.score);

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      rand_in     = rand_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      cur_in      = cur_ff;
      acc_in      = acc_ff;
      total_in    = total_ff;
      r_in        = r_ff;
      best_pos_in = best_pos_ff;
      res_pos_in  = res_pos_ff;
      res_id_in   = res_id_ff;
      res_zero_in = res_zero_ff;
      mod_start   = 1'b0;
      cmd         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in     = req_kind_type'(req_type);
               rand_in     = req_random_value;
               res_pos_in  = '0;
               res_id_in   = '0;
               res_zero_in = 1'b0;
               i_in        = '0;
               j_in        = '0;
               acc_in      = '0;
               cmd.rd_addr = '0;
               case (req_kind_type'(req_type))
                  REQ_WRITE: begin
                     if (CNT_BITS'(req_position) < CNT_BITS'(MAX_ENTRIES)
                         || POS_BITS < CNT_BITS) begin
                        cmd.wr_en = (USE_BITS'(req_position) < USE_BITS'(MAX_ENTRIES));
                     end
                     cmd.wr_addr       = IDX_BITS'(req_position);
                     cmd.wr_data.score = SCORE_BITS'(req_score);
                     cmd.wr_data.id    = req_entry_id;
                     state_in          = ST_EMIT;
                  end
                  REQ_SORT: begin
                     if (last_idx == '0) begin
                        state_in = ST_EMIT;
                     end else begin
                        cmd.rd_en = 1'b1;
                        state_in  = ST_SORT_LOAD;
                     end
                  end
                  REQ_SELECT: begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_SUM;
                  end
                  default: begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_ARG_SCAN;
                  end
               endcase
            end
         end

         ST_SORT_LOAD: begin
            // rd holds entry i; start the inner pass at i+1
            cur_in      = rd;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = i_ff + 1'b1;
            j_in        = i_ff + 1'b1;
            state_in    = ST_SORT_SCAN;
         end

         ST_SORT_SCAN: begin
            // write j while reading j+1: never the same entry
            if (cur_ff.score < rd.score) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = j_ff;
               cmd.wr_data = cur_ff;
               cur_in      = rd;
            end
            if (j_ff == last_idx) begin
               state_in = ST_SORT_STORE;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = j_ff + 1'b1;
               j_in        = j_ff + 1'b1;
            end
         end

         ST_SORT_STORE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = i_ff;
            cmd.wr_data = cur_ff;
            if (i_ff + 1'b1 == last_idx) begin
               state_in = ST_EMIT;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = i_ff + 1'b1;
               i_in        = i_ff + 1'b1;
               state_in    = ST_SORT_LOAD;
            end
         end

         ST_SUM: begin
            acc_in = run_sum;
            if (j_ff == last_idx) begin
               total_in = run_sum;
               if (run_sum == '0) begin
                  res_pos_in  = POS_BITS'(j_ff);
                  res_id_in   = rd.id;
                  res_zero_in = 1'b1;
                  state_in    = ST_EMIT;
               end else begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = j_ff + 1'b1;
               j_in        = j_ff + 1'b1;
            end
         end

         ST_MOD: begin
            if (mod_done) begin
               r_in        = mod_rem;
               acc_in      = '0;
               j_in        = '0;
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = '0;
               state_in    = ST_SEL_SCAN;
            end
         end

         ST_SEL_SCAN: begin
            acc_in = run_sum;
            if (run_sum > r_ff || j_ff == last_idx) begin
               res_pos_in = POS_BITS'(j_ff);
               res_id_in  = rd.id;
               state_in   = ST_EMIT;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = j_ff + 1'b1;
               j_in        = j_ff + 1'b1;
            end
         end

         ST_ARG_SCAN: begin
            if (j_ff == '0 || rd.score > cur_ff.score) begin
               cur_in      = rd;
               best_pos_in = j_ff;
            end
            if (j_ff == last_idx) begin
               if (j_ff == '0 || rd.score > cur_ff.score) begin
                  res_pos_in = POS_BITS'(j_ff);
                  res_id_in  = rd.id;
               end else begin
                  res_pos_in = POS_BITS'(best_pos_ff);
                  res_id_in  = cur_ff.id;
               end
               state_in = ST_EMIT;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = j_ff + 1'b1;
               j_in        = j_ff + 1'b1;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_EMIT && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= CFG_BITS'(CFG_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      rand_ff     <= rand_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      cur_ff      <= cur_in;
      acc_ff      <= acc_in;
      total_ff    <= total_in;
      r_ff        <= r_in;
      best_pos_ff <= best_pos_in;
      res_pos_ff  <= res_pos_in;
      res_id_ff   <= res_id_in;
      res_zero_ff <= res_zero_in;
      if (state_ff == ST_EMIT && out_free) begin
         rsp_pos_ff  <= res_pos_ff;
         rsp_id_ff   <= res_id_ff;
         rsp_zero_ff <= res_zero_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_chosen_position = rsp_pos_ff;
   assign rsp_chosen_id       = rsp_id_ff;
   assign rsp_zero_total      = rsp_zero_ff;

   `FTRS_ASSERT_IMP(a_sel_rem_below_total, clock, reset, state_ff == ST_SEL_SCAN, r_ff < total_ff)
   `FTRS_ASSERT_IMP(a_sort_j_after_i, clock, reset, state_ff == ST_SORT_SCAN, j_ff > i_ff)
   `FTRS_ASSERT_NXT(a_one_request, clock, reset, req_valid && req_ready, !req_ready)
   `FTRS_ASSERT_IMP(a_zero_from_select, clock, reset, state_ff == ST_EMIT && res_zero_ff, kind_ff == REQ_SELECT)

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fitness table with roulette-wheel selection.
// Requests are queued by the stimulus process and sent by a bursty driver.
// A local copy of the score and id tables works out the expected pick for
// every accepted request. A monitor with its own stall pattern checks each
// result transfer in order. The entries-in-use register is swept between
// phases, including 0, 1, 64 and values above the table size.
// ----------------------------------------------------------------------------
module tb;
   import ftrs_pkg::*;

   localparam int MAX_GAP      = 12;
   localparam int MAX_STALL    = 30;
   localparam int PHASE_ITEMS  = 120;

   typedef struct packed {
      req_kind_type           kind;
      logic [POS_BITS-1:0]    position;
      logic [IN_SCORE_BITS-1:0] score;
      logic [ID_BITS-1:0]     entry_id;
      logic [RAND_BITS-1:0]   random_value;
   } table_req_type;

   typedef struct packed {
      logic [POS_BITS-1:0] pos;
      logic [ID_BITS-1:0]  id;
      logic                zero;
   } pick_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_SPARSE,
      RDY_LONG
   } ready_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [TYPE_BITS-1:0]     req_type = '0;
   logic [POS_BITS-1:0]      req_position = '0;
   logic [IN_SCORE_BITS-1:0] req_score = '0;
   logic [ID_BITS-1:0]       req_entry_id = '0;
   logic [RAND_BITS-1:0]     req_random_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [POS_BITS-1:0]      rsp_chosen_position;
   logic [ID_BITS-1:0]       rsp_chosen_id;
   logic                     rsp_zero_total;
   logic                     csr_wr_en = 1'b0;
   logic [CFG_BITS-1:0]      csr_wr_data = '0;

   // local copy of the table state
   logic [SCORE_BITS-1:0] fit_score [MAX_ENTRIES];
   logic [ID_BITS-1:0]    fit_id    [MAX_ENTRIES];
   logic [CFG_BITS-1:0]   entries_cfg;

   table_req_type queued_reqs [$];
   pick_type      expected_picks [$];
   table_req_type on_bus;
   int         open_items = 0;
   int         errors = 0;
   longint     cycle_count = 0;
   longint     cycle_budget = 0;
   int         burst_left = 1;
   int         gap_left = 0;
   ready_mode_type ready_mode = RDY_ALWAYS;
   int         mode_left = 0;
   int         stall_left = 0;

   fitness_table_roulette_select_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_position       (req_position),
      .req_score          (req_score),
      .req_entry_id       (req_entry_id),
      .req_random_value   (req_random_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_chosen_position(rsp_chosen_position),
      .rsp_chosen_id      (rsp_chosen_id),
      .rsp_zero_total     (rsp_zero_total),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int entries_covered();
      if (entries_cfg == 0) begin
         return 1;
      end
      if (entries_cfg > MAX_ENTRIES) begin
         return MAX_ENTRIES;
      end
      return int'(entries_cfg);
   endfunction

   // applies one request to the local tables and returns the pick it yields
   function automatic pick_type run_table_request(table_req_type it);
      pick_type              res;
      int                    n;
      int                    pick;
      logic [31:0]           total;
      logic [31:0]           wheel_pos;
      logic [31:0]           run;
      logic                  found;
      logic [SCORE_BITS-1:0] s;
      logic [ID_BITS-1:0]    d;
      res = '0;
      n = entries_covered();
      pick = 0;
      case (it.kind)
         REQ_WRITE: begin
            fit_score[it.position] = it.score;
            fit_id[it.position] = it.entry_id;
         end
         REQ_SORT: begin
            for (int i = 0; i < n; i++) begin
               for (int j = i + 1; j < n; j++) begin
                  if (fit_score[i] < fit_score[j]) begin
                     s = fit_score[i];
                     d = fit_id[i];
                     fit_score[i] = fit_score[j];
                     fit_id[i] = fit_id[j];
                     fit_score[j] = s;
                     fit_id[j] = d;
                  end
               end
            end
         end
         REQ_SELECT: begin
            total = '0;
            for (int i = 0; i < n; i++) begin
               total += fit_score[i];
            end
            pick = n - 1;
            if (total == 0) begin
               res.zero = 1'b1;
            end else begin
               // each entry owns a slice of the wheel as wide as its score
               wheel_pos = {1'b0, it.random_value} % total;
               run = '0;
               found = 1'b0;
               for (int i = 0; i < n; i++) begin
                  run += fit_score[i];
                  if (!found && run > wheel_pos) begin
                     pick = i;
                     found = 1'b1;
                  end
               end
            end
            res.pos = POS_BITS'(pick);
            res.id = fit_id[pick];
         end
         default: begin
            for (int i = 1; i < n; i++) begin
               if (fit_score[i] > fit_score[pick]) begin
                  pick = i;
               end
            end
            res.pos = POS_BITS'(pick);
            res.id = fit_id[pick];
         end
      endcase
      return res;
   endfunction

   // worst-case cycles of one request at the current table size
   function automatic int request_cycles(req_kind_type kind);
      int n;
      n = entries_covered();
      case (kind)
         REQ_WRITE:  return 2;
         REQ_SORT:   return n * (n - 1) / 2 + 2 * n;
         REQ_SELECT: return 2 * n + 34;
         default:    return n + 2;
      endcase
   endfunction

   task automatic queue_item(input table_req_type it);
      queued_reqs.insert(queued_reqs.size(), it);
      open_items++;
      cycle_budget += request_cycles(it.kind) + MAX_GAP + MAX_STALL + 8;
   endtask

   task automatic queue_fields(input req_kind_type kind, input int pos, input int score,
                               input int id, input logic [RAND_BITS-1:0] rnd);
      table_req_type it;
      it.kind = kind;
      it.position = POS_BITS'(pos);
      it.score = IN_SCORE_BITS'(score);
      it.entry_id = ID_BITS'(id);
      it.random_value = rnd;
      queue_item(it);
   endtask

   function automatic table_req_type random_req();
      table_req_type it;
      int         roll;
      int         n;
      n = entries_covered();
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         it.kind = REQ_WRITE;
      end else if (roll < 75) begin
         it.kind = REQ_SELECT;
      end else if (roll < 88) begin
         it.kind = REQ_ARGMAX;
      end else begin
         it.kind = REQ_SORT;
      end
      // mostly hit the entries in use so writes matter
      if ($urandom_range(0, 3) != 0) begin
         it.position = POS_BITS'($urandom_range(0, n - 1));
      end else begin
         it.position = POS_BITS'($urandom);
      end
      case ($urandom_range(0, 3))
         0:       it.score = '0;
         1:       it.score = IN_SCORE_BITS'($urandom_range(1, 4));
         2:       it.score = IN_SCORE_BITS'($urandom);
         default: it.score = 16'hFFFF - IN_SCORE_BITS'($urandom_range(0, 1));
      endcase
      it.entry_id = ID_BITS'($urandom);
      case ($urandom_range(0, 9))
         0:       it.random_value = '0;
         1:       it.random_value = '1;
         default: it.random_value = RAND_BITS'($urandom);
      endcase
      return it;
   endfunction

   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (open_items != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_entries_in_use(input logic [CFG_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      entries_cfg = value;
      cycle_budget += 32;
   endtask

   // stimulus
   initial begin
      logic [CFG_BITS-1:0] sweep [16];
      int                  n;
      sweep = '{7'd1, 7'd0, 7'd2, 7'd3, 7'd5, 7'd8, 7'd16, 7'd31,
                7'd33, 7'd48, 7'd63, 7'd64, 7'd65, 7'd127, 7'd100, 7'd0};
      sweep[15] = CFG_BITS'($urandom_range(0, 127));
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         fit_score[i] = '0;
         fit_id[i] = ID_BITS'(i);
      end
      entries_cfg = CFG_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset size of 64
      queue_fields(REQ_SELECT, 0, 0, 0, '1);          // empty wheel: last entry, flag set
      queue_fields(REQ_ARGMAX, 63, 16'hFFFF, 63, '0); // all tied: first entry
      queue_fields(REQ_SORT, 0, 0, 0, '0);            // equal scores keep their order
      queue_fields(REQ_ARGMAX, 0, 0, 0, '0);
      queue_fields(REQ_WRITE, 63, 16'hFFFF, 0, '0);
      queue_fields(REQ_WRITE, 0, 16'hFFFF, 63, '1);
      queue_fields(REQ_ARGMAX, 0, 0, 0, '0);          // tie at both ends
      queue_fields(REQ_SELECT, 0, 0, 0, '0);
      queue_fields(REQ_SELECT, 0, 0, 0, 31'd65535);   // lands past the zero-score run
      queue_fields(REQ_SELECT, 0, 0, 0, '1);
      queue_fields(REQ_WRITE, 32, 1, 42, '0);
      queue_fields(REQ_WRITE, 5, 16'h8000, 21, '0);
      queue_fields(REQ_SORT, 0, 0, 0, '0);
      queue_fields(REQ_ARGMAX, 0, 0, 0, '0);
      queue_fields(REQ_SELECT, 0, 0, 0, 31'd131070);
      queue_fields(REQ_SELECT, 0, 0, 0, 31'd163838); // last slot of the one-point entry
      queue_fields(REQ_SELECT, 0, 0, 0, RAND_BITS'($urandom));
      wait_drained();

      for (int p = 0; p < 16; p++) begin
         write_entries_in_use(sweep[p]);
         n = entries_covered();
         // every fourth phase starts from an all-zero wheel
         if (p % 4 == 3) begin
            for (int i = 0; i < n; i++) begin
               queue_fields(REQ_WRITE, i, 0, $urandom, '0);
            end
            queue_fields(REQ_SELECT, 0, 0, 0, RAND_BITS'($urandom));
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            queue_item(random_req());
         end
         wait_drained();
      end

      repeat (100) @(posedge clock);
      if (errors == 0 && expected_picks.size() == 0) begin
         $display("** fitness_table_roulette_select_core: PASSED **");
      end else begin
         $display("** fitness_table_roulette_select_core: FAILED **");
      end
      $finish;
   end

   // request driver: bursts of transfers with random gaps
   always @(posedge clock) begin
      logic send;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_picks.insert(expected_picks.size(), run_table_request(on_bus));
         end
         send = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (queued_reqs.size() > 0) begin
            on_bus = queued_reqs.pop_front();
            send = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            end
         end
         req_valid <= send;
         if (send) begin
            req_type <= on_bus.kind;
            req_position <= on_bus.position;
            req_score <= on_bus.score;
            req_entry_id <= on_bus.entry_id;
            req_random_value <= on_bus.random_value;
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // result monitor with its own stall pattern
   always @(posedge clock) begin
      pick_type want;
      logic     nxt_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_picks.size() == 0) begin
               errors++;
               $display("%0t: result with none expected, expected none, actual %0d/%0d/%0d",
                        $time, rsp_chosen_position, rsp_chosen_id, rsp_zero_total);
            end else begin
               want = expected_picks.pop_front();
               open_items--;
               check_field("chosen_position", want.pos, rsp_chosen_position);
               check_field("chosen_id", want.id, rsp_chosen_id);
               check_field("zero_total", want.zero, rsp_zero_total);
            end
         end
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 400);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            RDY_ALWAYS: nxt_ready = 1'b1;
            RDY_COIN:   nxt_ready = 1'($urandom_range(0, 1));
            RDY_SPARSE: nxt_ready = ($urandom_range(0, 5) == 0);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  nxt_ready = 1'b0;
               end else begin
                  stall_left = $urandom_range(1, MAX_STALL);
                  nxt_ready = 1'b1;
               end
            end
         endcase
         rsp_ready <= nxt_ready;
      end
   end

   // watchdog: several times the worst-case cycles of everything queued so far
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 4 * cycle_budget + 20000) begin
         $display("%0t: timeout with %0d requests outstanding", $time, open_items);
         $display("** fitness_table_roulette_select_core: FAILED **");
         $finish;
      end
   end

endmodule

[fitness_table_roulette_select_core.f]
+incdir+src
src/ftrs_pkg.sv
src/ftrs_table.sv
src/ftrs_mod.sv
src/fitness_table_roulette_select_core.sv
tb/tb.sv
